// ----- rtl/core/tci_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tci_pkg;

  // Curve geometry
  localparam int NUM_POINTS = 6;
  localparam int PT_IDX_W   = 3;
  localparam int SPEED_W    = 16;
  localparam int PCT_W      = 8;

  // Item and register widths
  localparam int RATE_W     = 20;
  localparam int COUNT_W    = 3;
  localparam int DIVISOR_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Shared divider: dividend/quotient width and step count
  localparam int QUO_W      = 24;
  localparam int DIV_STEPS  = 24;
  localparam int DIV_CNT_W  = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd7;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 3'd6;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd32;

  typedef struct packed {
    logic [PCT_W-1:0]   pct;
    logic [SPEED_W-1:0] speed;
  } point_t;

  typedef struct packed {
    point_t [NUM_POINTS-1:0] points;
    logic [COUNT_W-1:0]      point_count;
    logic [DIVISOR_W-1:0]    divisor;
  } cfg_t;

  // Request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [QUO_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_START,
    ST_DIV_SPAN,
    ST_FINISH
  } ctrl_state_e;

  // Default curve point after reset
  function automatic point_t point_reset(input logic [PT_IDX_W-1:0] idx);
    point_t p;
    p = '0;
    unique case (idx)
      3'd0:    p = '{pct: 8'd100, speed: 16'd0};
      3'd1:    p = '{pct: 8'd88,  speed: 16'd400};
      3'd2:    p = '{pct: 8'd71,  speed: 16'd800};
      3'd3:    p = '{pct: 8'd50,  speed: 16'd1200};
      3'd4:    p = '{pct: 8'd25,  speed: 16'd2000};
      3'd5:    p = '{pct: 8'd8,   speed: 16'd3000};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tci_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, shared by both divisions
module tci_div
  import tci_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0]     quo_q, quo_d;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One shift-compare-subtract step
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // A new division only starts on an idle unit
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  // Done follows the last step
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == DIV_CNT_W'(1)) |=> (done_q && !busy_q))
    else $error("divider done missing after final step");

endmodule

`default_nettype wire

// ----- rtl/core/tci_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: rate division, segment search, numerator build, span division
module tci_ctrl
  import tci_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [RATE_W-1:0] step_rate_i,
  output div_req_t               div_req_o,
  input  wire div_rsp_t          div_rsp_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [PCT_W-1:0]       res_data_o
);

  ctrl_state_e          state_q, state_d;
  logic [RATE_W-1:0]    s_q, s_d;
  logic [PT_IDX_W-1:0]  idx_q, idx_d;
  logic [SPEED_W-1:0]   prev_x_q, prev_x_d;
  logic [PCT_W-1:0]     prev_y_q, prev_y_d;
  logic [SPEED_W-1:0]   cur_x_q, cur_x_d;
  logic [PCT_W-1:0]     cur_y_q, cur_y_d;
  logic [QUO_W-1:0]     acc_q, acc_d;
  logic [PCT_W-1:0]     res_q, res_d;

  logic [COUNT_W-1:0]   n_sat;
  logic [PT_IDX_W-1:0]  last;
  logic                 zero_case;
  logic [PT_IDX_W-1:0]  rd_idx;
  point_t               pt;
  logic [RATE_W-1:0]    pt_speed;
  logic [SPEED_W-1:0]   s16;
  logic [PCT_W-1:0]     mul_a;
  logic [SPEED_W-1:0]   mul_b;
  logic [QUO_W-1:0]     prod;

  // Point count saturates at the table size
  assign n_sat     = (cfg_i.point_count > COUNT_W'(NUM_POINTS)) ?
                     COUNT_W'(NUM_POINTS) : cfg_i.point_count;
  assign last      = PT_IDX_W'(n_sat - 1'b1);
  assign zero_case = (cfg_i.point_count == '0) || (cfg_i.divisor == '0);

  // Single read port onto the curve registers
  always_comb begin
    unique case (state_q)
      ST_CHK_LAST: rd_idx = last;
      ST_SEARCH:   rd_idx = idx_q;
      default:     rd_idx = '0;
    endcase
  end

  assign pt       = cfg_i.points[rd_idx];
  assign pt_speed = {{(RATE_W-SPEED_W){1'b0}}, pt.speed};

  // Inside a segment the full-step rate is at most x1, so it fits 16 bits
  assign s16 = s_q[SPEED_W-1:0];

  // Shared 8x16 multiplier
  always_comb begin
    if (state_q == ST_MUL_LO) begin
      mul_a = prev_y_q;
      mul_b = cur_x_q - s16;
    end else begin
      mul_a = cur_y_q;
      mul_b = s16 - prev_x_q;
    end
  end

  assign prod = {{(QUO_W-PCT_W){1'b0}}, mul_a} * {{(QUO_W-SPEED_W){1'b0}}, mul_b};

  // Next state and outputs
  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    idx_d    = idx_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    acc_d    = acc_q;
    res_d    = res_q;

    in_ready_o         = 1'b0;
    res_valid_o        = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = {{(QUO_W-RATE_W){1'b0}}, step_rate_i};
    div_req_o.divisor  = cfg_i.divisor;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (zero_case) begin
            res_d   = '0;
            state_d = ST_FINISH;
          end else begin
            div_req_o.start = 1'b1;
            state_d         = ST_DIV_RATE;
          end
        end
      end
      ST_DIV_RATE: begin
        if (div_rsp_i.done) begin
          s_d     = div_rsp_i.quotient[RATE_W-1:0];
          state_d = ST_CHK_FIRST;
        end
      end
      // At or below the first point
      ST_CHK_FIRST: begin
        if (s_q <= pt_speed) begin
          res_d   = pt.pct;
          state_d = ST_FINISH;
        end else begin
          prev_x_d = pt.speed;
          prev_y_d = pt.pct;
          idx_d    = PT_IDX_W'(1);
          state_d  = ST_CHK_LAST;
        end
      end
      // At or above the last point in use
      ST_CHK_LAST: begin
        if (s_q >= pt_speed) begin
          res_d   = pt.pct;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      // First point not below the rate closes the segment
      ST_SEARCH: begin
        if (s_q <= pt_speed) begin
          cur_x_d = pt.speed;
          cur_y_d = pt.pct;
          state_d = ST_MUL_LO;
        end else begin
          prev_x_d = pt.speed;
          prev_y_d = pt.pct;
          idx_d    = idx_q + 1'b1;
        end
      end
      ST_MUL_LO: begin
        acc_d   = prod;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_d   = acc_q + prod;
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = acc_q;
        div_req_o.divisor  = cur_x_q - prev_x_q;
        state_d            = ST_DIV_SPAN;
      end
      ST_DIV_SPAN: begin
        if (div_rsp_i.done) begin
          res_d   = div_rsp_i.quotient[PCT_W-1:0];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    idx_q    <= idx_d;
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
  end

  assign res_data_o = res_q;

  // Divider answers only while a division is awaited
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_DIV_RATE || state_q == ST_DIV_SPAN))
    else $error("unexpected divider completion");

  // Search never runs past the last point in use
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (idx_q <= last))
    else $error("segment search overran the curve");

  // Segment span is never zero
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_START) |-> (cur_x_q > prev_x_q))
    else $error("zero segment span");

endmodule

`default_nettype wire

// ----- rtl/core/torque_curve_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Torque curve interpolator.
// Input channel: in_valid_i/in_ready_o with step_rate_i (microsteps per second).
// Output channel: out_valid_o/out_ready_i with torque_percent_o, one result
// per input transfer, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0-5 curve
// points, 6 point count, 7 microstep divisor); write only while idle.
// Each item runs on one shared 24-step restoring divider: first the rate
// divided by the microstep divisor, then, for a rate inside the curve, the
// interpolation numerator divided by the segment span; a segment search of
// one point per cycle and two multiply steps come in between.
// A zero count or divisor gives 0 with no division; a rate at or beyond
// either end of the curve gives that end point's percent with no second one.
// One item is in work at a time, until its result enters the output register.
// The output register frees the core, so the next item is taken while a
// result still waits; if the receiver stalls longer, the core holds its
// result and input ready stays low.
// Reset restores the default six-point curve, count 6, divisor 32.
module torque_curve_interpolator
  import tci_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [RATE_W-1:0]     step_rate_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PCT_W-1:0]           torque_percent_o
);

  point_t [NUM_POINTS-1:0] points_q;
  logic [COUNT_W-1:0]      count_q;
  logic [DIVISOR_W-1:0]    divisor_q;
  cfg_t                    cfg;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    res_valid;
  logic                    res_ready;
  logic [PCT_W-1:0]        res_data;

  logic                    out_valid_q;
  logic [PCT_W-1:0]        torque_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        points_q[i] <= point_reset(PT_IDX_W'(i));
      end
      count_q   <= COUNT_RESET;
      divisor_q <= DIVISOR_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < REG_POINT_A + CFG_IDX_W'(NUM_POINTS)) begin
        points_q[cfg_idx_i - REG_POINT_A] <= cfg_data_i;
      end else if (cfg_idx_i == REG_POINT_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end else if (cfg_idx_i == REG_DIVISOR) begin
        divisor_q <= cfg_data_i[DIVISOR_W-1:0];
      end
    end
  end

  assign cfg.points      = points_q;
  assign cfg.point_count = count_q;
  assign cfg.divisor     = divisor_q;

  tci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .step_rate_i (step_rate_i),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  tci_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: loads when empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      torque_q <= res_data;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign torque_percent_o = torque_q;

  // A held result is never overwritten by the core
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(torque_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
